FILE: hdl/esp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package esp_pkg;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_SPEED_COEFF     = 2'd0;
  localparam logic [IDX_W-1:0] REG_COUNTS_PER_TURN = 2'd1;
  localparam logic [IDX_W-1:0] REG_CLOCK_HZ        = 2'd2;

  // field widths
  localparam int COEFF_W  = 16;
  localparam int CPT_W    = 21;
  localparam int HZ_W     = 30;
  localparam int TICK_W   = 32;
  localparam int SPEED_W  = 32;
  localparam int POS_W    = 64;
  localparam int INTURN_W = 21;
  localparam int TURNS_W  = 32;

  // shared multiplier operand width, divisor width and width of 60*coeff
  localparam int MUL_W = 32;
  localparam int DVS_W = 53;
  localparam int K_W   = 22;

  localparam logic [COEFF_W-1:0] COEFF_RST = 16'd1;
  localparam logic [CPT_W-1:0]   CPT_RST   = 21'd2500;
  localparam logic [HZ_W-1:0]    HZ_RST    = 30'd168000000;

  typedef struct packed {
    logic [COEFF_W-1:0] speed_coeff;
    logic [CPT_W-1:0]   counts_per_turn;
    logic [HZ_W-1:0]    clock_hz;
  } esp_cfg_t;

endpackage
`default_nettype wire

FILE: hdl/esp_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module esp_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [esp_pkg::ADDR_W-1:0]   paddr,
  input  logic [esp_pkg::DATA_W-1:0]   pwdata,
  output logic [esp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output esp_pkg::esp_cfg_t            cfg
);
  import esp_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_coeff     <= COEFF_RST;
      cfg.counts_per_turn <= CPT_RST;
      cfg.clock_hz        <= HZ_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SPEED_COEFF:     cfg.speed_coeff     <= pwdata[COEFF_W-1:0];
        REG_COUNTS_PER_TURN: cfg.counts_per_turn <= pwdata[CPT_W-1:0];
        REG_CLOCK_HZ:        cfg.clock_hz        <= pwdata[HZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SPEED_COEFF:     prdata = DATA_W'(cfg.speed_coeff);
      REG_COUNTS_PER_TURN: prdata = DATA_W'(cfg.counts_per_turn);
      REG_CLOCK_HZ:        prdata = DATA_W'(cfg.clock_hz);
      default:             prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/esp_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module esp_mul (
  input  logic                          clk,
  input  logic [esp_pkg::MUL_W-1:0]     op_a,
  input  logic [esp_pkg::MUL_W-1:0]     op_b,
  output logic [2*esp_pkg::MUL_W-1:0]   prod
);
  import esp_pkg::*;

  // one registered 32x32 product per cycle
  always_ff @(posedge clk) begin
    prod <= (2*MUL_W)'(op_a) * (2*MUL_W)'(op_b);
  end

endmodule
`default_nettype wire

FILE: hdl/esp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module esp_div #(
  parameter int QW = 66
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [QW-1:0]              dividend,
  input  logic [esp_pkg::DVS_W-1:0]  divisor,
  input  logic [$clog2(QW+1)-1:0]    nsteps,
  output logic                       done,
  output logic [QW-1:0]              quot,
  output logic [esp_pkg::DVS_W-1:0]  rem
);
  import esp_pkg::*;

  localparam int CW = $clog2(QW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // restoring step: dividend bits leave at the top, quotient bits enter at the bottom
  assign trial = {rem, quot[QW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= nsteps;
        quot <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        quot <= {quot[QW-2:0], ge};
        rem  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/encoder_speed_position_feedback_core.sv
`timescale 1ns / 1ps
`default_nettype none
// incremental encoder speed and position feedback. each input word is one sample: the signed
// pulse change since the last sample and the current free-running tick value. the first word
// after reset only records the tick and returns an all-zero word with valid_res low. every later
// word returns speed_fb = 60*speed_coeff*pulse_delta*clock_hz / counts_per_turn / elapsed_ticks
// (truncated toward zero, saturated to 32 bits, 0 when elapsed or counts_per_turn is 0), the
// running 64-bit position_total, and its truncated remainder and quotient by counts_per_turn.
// one sample is worked at a time: in_stall is high from acceptance until the result is in the
// output register. a priming sample goes straight to S_OUT; a full sample makes four
// passes through the shared 32x32 multiplier and then runs the one-bit-per-cycle restoring
// divider, DELTA_BITS + 51 steps for speed and 64 steps for position. a finished word that
// finds the output register still held by out_stall waits for it. the output register lets a
// new sample be taken while the last result still waits on out_stall. registers sit at byte
// addresses 0, 4 and 8.
module encoder_speed_position_feedback_core #(
  parameter int DELTA_BITS = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [esp_pkg::ADDR_W-1:0]          paddr,
  input  logic [esp_pkg::DATA_W-1:0]          pwdata,
  output logic [esp_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  // sample input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [DELTA_BITS-1:0]        pulse_delta,
  input  logic [esp_pkg::TICK_W-1:0]          tick_now,
  // feedback output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                valid_res,
  output logic signed [esp_pkg::SPEED_W-1:0]  speed_fb,
  output logic signed [esp_pkg::POS_W-1:0]    position_total,
  output logic signed [esp_pkg::INTURN_W-1:0] position_in_turn,
  output logic signed [esp_pkg::TURNS_W-1:0]  turns
);
  import esp_pkg::*;

  // numerator 60*coeff*|delta|*clock_hz stays below 2^(DELTA_BITS+51)
  localparam int NUM_W = DELTA_BITS + 51;
  localparam int QW    = (NUM_W > POS_W) ? NUM_W : POS_W;
  localparam int CW    = $clog2(QW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MK, S_M1, S_M2, S_M3, S_M4, S_SDIV, S_POS, S_PDIV, S_OUT
  } state_t;

  esp_cfg_t cfg;

  state_t              state;
  logic                primed;
  logic [TICK_W-1:0]   last_tick;
  logic [POS_W-1:0]    position_acc;
  logic [TICK_W-1:0]   elapsed;
  logic                dneg;
  logic [MUL_W-1:0]    dmag;
  logic [MUL_W-1:0]    a_hi;
  logic [2*MUL_W-1:0]  p0;
  logic [2*MUL_W-1:0]  p1;
  logic                pneg;
  logic [POS_W-1:0]    pmag;

  // staged result, copied to the output register when it is free
  logic                res_valid;
  logic [SPEED_W-1:0]  res_speed;
  logic [INTURN_W-1:0] res_inturn;
  logic [TURNS_W-1:0]  res_turns;

  logic [K_W-1:0]      k;
  logic [MUL_W-1:0]    delta_u;
  logic [MUL_W-1:0]    delta_mag;
  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;
  logic [2*MUL_W-1:0]  mul_prod;
  logic [3*MUL_W-1:0]  num_sum;
  logic                speed_go;
  logic                cpt_nz;

  logic                div_start;
  logic [QW-1:0]       div_dividend;
  logic [DVS_W-1:0]    div_divisor;
  logic [CW-1:0]       div_nsteps;
  logic                div_done;
  logic [QW-1:0]       div_quot;
  logic [DVS_W-1:0]    div_rem;
  logic                quot_big;

  function automatic logic [31:0] sat32(input logic neg, input logic big,
                                        input logic [31:0] mag);
    logic [31:0] r;
    if (neg) begin
      r = (big || mag[31]) ? 32'h8000_0000 : (32'd0 - mag);
    end else begin
      r = (big || mag[31]) ? 32'h7FFF_FFFF : mag;
    end
    return r;
  endfunction

  esp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  esp_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_prod)
  );

  esp_div #(.QW(QW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .nsteps   (div_nsteps),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // 60*coeff as shift and subtract
  assign k = (K_W'(cfg.speed_coeff) << 6) - (K_W'(cfg.speed_coeff) << 2);

  // sign-extended pulse change and its magnitude
  assign delta_u   = MUL_W'(pulse_delta);
  assign delta_mag = pulse_delta[DELTA_BITS-1] ? (MUL_W'(0) - delta_u) : delta_u;

  assign cpt_nz   = cfg.counts_per_turn != '0;
  assign speed_go = (elapsed != '0) && cpt_nz;
  assign num_sum  = {{MUL_W{1'b0}}, p0} + {p1, {MUL_W{1'b0}}};
  assign quot_big = |div_quot[QW-1:32];

  assign in_stall = state != S_IDLE;

  // operand select for the shared multiplier; the product is ready in the following cycle
  always_comb begin
    unique case (state)
      S_MK: begin
        mul_a = MUL_W'(k);
        mul_b = dmag;
      end
      S_M1: begin
        mul_a = mul_prod[MUL_W-1:0];
        mul_b = MUL_W'(cfg.clock_hz);
      end
      S_M2: begin
        mul_a = a_hi;
        mul_b = MUL_W'(cfg.clock_hz);
      end
      S_M3: begin
        mul_a = MUL_W'(cfg.counts_per_turn);
        mul_b = elapsed;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider command: speed division left-aligned numerator, then position magnitude
  always_comb begin
    if (state == S_M4) begin
      div_start    = speed_go;
      div_dividend = QW'(num_sum[NUM_W-1:0]) << (QW - NUM_W);
      div_divisor  = mul_prod[DVS_W-1:0];
      div_nsteps   = CW'(NUM_W);
    end else begin
      div_start    = (state == S_POS) && cpt_nz;
      div_dividend = QW'(pmag) << (QW - POS_W);
      div_divisor  = DVS_W'(cfg.counts_per_turn);
      div_nsteps   = CW'(POS_W);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      primed       <= 1'b0;
      last_tick    <= '0;
      position_acc <= '0;
      out_valid    <= 1'b0;
    end else begin
      // output word taken and nothing new loaded in its place
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_tick <= tick_now;
            elapsed   <= tick_now - last_tick;
            dneg      <= pulse_delta[DELTA_BITS-1];
            dmag      <= delta_mag;
            if (!primed) begin
              // priming sample only records the tick
              primed     <= 1'b1;
              res_valid  <= 1'b0;
              res_speed  <= '0;
              res_inturn <= '0;
              res_turns  <= '0;
              state      <= S_OUT;
            end else begin
              position_acc <= position_acc + POS_W'(pulse_delta);
              res_valid    <= 1'b1;
              state        <= S_MK;
            end
          end
        end
        S_MK: begin
          pneg  <= position_acc[POS_W-1];
          pmag  <= position_acc[POS_W-1] ? (POS_W'(0) - position_acc) : position_acc;
          state <= S_M1;
        end
        S_M1: begin
          // product holds 60*coeff*|delta|
          a_hi  <= mul_prod[2*MUL_W-1:MUL_W];
          state <= S_M2;
        end
        S_M2: begin
          p0    <= mul_prod;
          state <= S_M3;
        end
        S_M3: begin
          p1    <= mul_prod;
          state <= S_M4;
        end
        S_M4: begin
          // product holds counts_per_turn*elapsed, the speed divisor
          if (speed_go) begin
            state <= S_SDIV;
          end else begin
            res_speed <= '0;
            state     <= S_POS;
          end
        end
        S_SDIV: begin
          if (div_done) begin
            res_speed <= sat32(dneg, quot_big, div_quot[31:0]);
            state     <= S_POS;
          end
        end
        S_POS: begin
          if (cpt_nz) begin
            state <= S_PDIV;
          end else begin
            res_inturn <= '0;
            res_turns  <= '0;
            state      <= S_OUT;
          end
        end
        S_PDIV: begin
          if (div_done) begin
            res_turns  <= sat32(pneg, quot_big, div_quot[31:0]);
            res_inturn <= pneg ? (INTURN_W'(0) - div_rem[INTURN_W-1:0])
                               : div_rem[INTURN_W-1:0];
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          // wait for the output register to be free or taken this cycle
          if (!out_valid || !out_stall) begin
            out_valid        <= 1'b1;
            valid_res        <= res_valid;
            speed_fb         <= res_speed;
            position_total   <= res_valid ? position_acc : '0;
            position_in_turn <= res_inturn;
            turns            <= res_turns;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
